/* rtl/core/dsce_pkg.sv */
// Package for the SPI command engine: payload structs, register numbers,
// function codes and the CRC5 bit step. No dependencies.
`default_nettype none

package dsce_pkg;

  // Sizes
  localparam int BOARDS_DEF     = 4;
  localparam int REGS_PER_BOARD = 16;

  // Function codes of a command transfer
  localparam logic [2:0] FN_SET_MODE    = 3'd0;
  localparam logic [2:0] FN_WRITE_LEVEL = 3'd1;
  localparam logic [2:0] FN_READ_REQ    = 3'd2;
  localparam logic [2:0] FN_INIT_FETCH  = 3'd3;
  localparam logic [2:0] FN_INIT_APPLY  = 3'd4;
  localparam logic [2:0] FN_RESPONSE    = 3'd5;

  localparam logic [2:0] MODE_BAD    = 3'd7;
  localparam logic [2:0] MODE_HIGH_Z = 3'd4;
  localparam logic [2:0] MODE_DI_ALT = 3'd6;

  // Chip register numbers
  localparam logic [3:0] R_SETOUT   = 4'd0;
  localparam logic [3:0] R_DOILEVEL = 4'd2;
  localparam logic [3:0] R_OPNWREN  = 4'd8;
  localparam logic [3:0] R_CONFIG1  = 4'd10;
  localparam logic [3:0] R_CONFIGDI = 4'd12;
  localparam logic [3:0] R_CONFIGDO = 4'd13;
  localparam logic [3:0] R_CURRLIM  = 4'd14;

  // CRC5
  localparam logic [4:0] CRC_SEED = 5'h1f;
  localparam logic [4:0] CRC_POLY = 5'h15;

  // Step classes
  localparam logic [1:0] CLS_FRAME  = 2'd0;
  localparam logic [1:0] CLS_REJECT = 2'd1;
  localparam logic [1:0] CLS_RESP   = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  board;
    logic [1:0]  chan;
    logic [2:0]  op_mode;
    logic        level;
    logic [3:0]  reg_addr;
    logic        store_flag;
    logic [23:0] rx_frame;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] tx_frame;
    logic        rx_ok;
    logic [7:0]  rx_data;
    logic        input_level;
    logic        bad_argument;
    logic        last;
  } result_t;

  // One frame or check, handed from the sequencer to the RMW stage
  typedef struct packed {
    logic [1:0]  cls;
    logic [1:0]  board;
    logic [3:0]  reg_addr;
    logic        wr;
    logic [7:0]  mask;
    logic [7:0]  val;
    logic        store;
    logic [1:0]  chan;
    logic [23:0] rx_frame;
    logic [4:0]  crc;
    logic        last;
  } step_t;

  // One MSB-first CRC5 bit step
  function automatic logic [4:0] crc5_step(logic [4:0] c, logic b);
    logic [4:0] n;
    n = {c[3:0], 1'b0};
    if (b ^ c[4]) begin
      n = n ^ CRC_POLY;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dsce_seq.sv */
// Command sequencer: holds the current command and issues one step per cycle
// while step_take is high (frame, reject or response check). Depends on dsce_pkg.
`default_nettype none

module dsce_seq #(
  parameter int BOARDS = dsce_pkg::BOARDS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire dsce_pkg::cmd_t cmd,
  output logic                step_valid,
  output dsce_pkg::step_t     step,
  input  wire logic           step_take
);
  import dsce_pkg::*;

  logic       active;
  cmd_t       cur;
  logic [3:0] idx;

  logic       issue;
  logic       fin;
  logic       accept;
  logic       rej;
  logic [3:0] nlast;
  logic [7:0] addr_byte;
  logic [4:0] crc_a;

  assign issue      = active && step_take;
  assign fin        = issue && step.last;
  assign cmd_stall  = active && !fin;
  assign accept     = cmd_valid && !cmd_stall;
  assign step_valid = active;

  // Command register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (accept) begin
      active <= (cmd.func <= FN_RESPONSE);
      idx    <= '0;
    end else if (fin) begin
      active <= 1'b0;
    end else if (issue) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cmd;
    end
  end

  assign rej = (cur.func != FN_RESPONSE) &&
               ((int'(cur.board) >= BOARDS) ||
                (cur.func == FN_SET_MODE && cur.op_mode == MODE_BAD));

  // Step decode: register, bit mask and new bit values
  always_comb begin
    step          = '0;
    step.cls      = CLS_FRAME;
    step.board    = cur.board;
    step.chan     = cur.chan;
    step.rx_frame = cur.rx_frame;
    nlast         = 4'd0;
    if (rej) begin
      step.cls = CLS_REJECT;
    end else begin
      case (cur.func)
        FN_SET_MODE: begin
          if (cur.op_mode inside {[3'd4:3'd6]}) begin
            nlast = 4'd2;
            case (idx)
              4'd0: begin
                step.reg_addr = R_SETOUT;
                step.mask     = 8'h10 << cur.chan;
                step.val      = step.mask;
              end
              4'd1: begin
                step.reg_addr = R_CONFIGDO;
                step.mask     = 8'h02 << {cur.chan, 1'b0};
                step.val      = (cur.op_mode == MODE_HIGH_Z) ? step.mask : 8'h00;
              end
              default: begin
                step.reg_addr = R_CONFIGDI;
                step.mask     = (cur.op_mode == MODE_HIGH_Z) ? 8'h00 : 8'h80;
                step.val      = (cur.op_mode == MODE_DI_ALT) ? 8'h80 : 8'h00;
              end
            endcase
          end else begin
            nlast = 4'd1;
            if (idx == 4'd0) begin
              step.reg_addr = R_SETOUT;
              step.mask     = 8'h10 << cur.chan;
            end else begin
              step.reg_addr = R_CONFIGDO;
              step.mask     = 8'h03 << {cur.chan, 1'b0};
              step.val      = {6'd0, cur.op_mode[1:0]} << {cur.chan, 1'b0};
            end
          end
          step.wr = 1'b1;
        end
        FN_WRITE_LEVEL: begin
          step.reg_addr = R_SETOUT;
          step.wr       = 1'b1;
          step.mask     = 8'h01 << cur.chan;
          step.val      = cur.level ? step.mask : 8'h00;
        end
        FN_READ_REQ: begin
          nlast = 4'd1;
          if (idx == 4'd0) begin
            step.reg_addr = R_CONFIGDI;
            step.wr       = 1'b1;
            step.mask     = 8'h10;
          end else begin
            step.reg_addr = R_DOILEVEL;
          end
        end
        FN_INIT_FETCH: begin
          nlast         = 4'd15;
          step.reg_addr = idx;
        end
        FN_INIT_APPLY: begin
          nlast   = 4'd2;
          step.wr = 1'b1;
          case (idx)
            4'd0: begin
              step.reg_addr = R_CONFIG1;
              step.mask     = 8'h03;
            end
            4'd1: begin
              step.reg_addr = R_OPNWREN;
              step.mask     = 8'hf0;
              step.val      = 8'hf0;
            end
            default: begin
              step.reg_addr = R_CURRLIM;
              step.mask     = 8'hff;
              step.val      = 8'hff;
            end
          endcase
        end
        default: begin
          step.cls      = CLS_RESP;
          step.reg_addr = cur.reg_addr;
          step.store    = cur.store_flag && (int'(cur.board) < BOARDS);
        end
      endcase
    end
    step.last = (idx == nlast);

    // Address-side CRC: address byte of a frame, or bits 2..7 of a response
    addr_byte = {step.board, 1'b0, step.reg_addr, step.wr};
    crc_a     = CRC_SEED;
    if (step.cls == CLS_RESP) begin
      for (int i = 21; i >= 16; i--) begin
        crc_a = crc5_step(crc_a, cur.rx_frame[i]);
      end
    end else begin
      for (int i = 7; i >= 0; i--) begin
        crc_a = crc5_step(crc_a, addr_byte[i]);
      end
    end
    step.crc = crc_a;
  end

endmodule

`default_nettype wire

/* rtl/core/dsce_exec.sv */
// Shadow register memory with read-modify-write stage, frame CRC and the
// result register. Depends on dsce_pkg.
`default_nettype none

module dsce_exec #(
  parameter int BOARDS = dsce_pkg::BOARDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_valid,
  input  wire dsce_pkg::step_t   step,
  output logic                   step_take,
  output logic                   res_valid,
  output dsce_pkg::result_t      res,
  input  wire logic              res_stall
);
  import dsce_pkg::*;

  localparam int DEPTH = BOARDS * REGS_PER_BOARD;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       rdata;
  logic             rd_vld;

  logic             b_valid;
  step_t            b_step;
  logic             b_fwd;
  logic [7:0]       b_fwd_data;

  logic             issue;
  logic             re;
  logic [AW-1:0]    raddr;
  logic             b_fire;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [7:0]       old;
  logic [7:0]       upd;
  logic [7:0]       dbyte;
  logic [2:0]       tail;
  logic [4:0]       crc;
  logic             ok;
  result_t          res_next;

  assign issue     = step_valid && step_take;
  assign re        = issue && (step.cls == CLS_FRAME);
  assign raddr     = AW'({step.board, step.reg_addr});
  assign b_fire    = b_valid && (!res_valid || !res_stall);
  assign step_take = !b_valid || b_fire;

  // Shadow memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Written-since-reset bits; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  // Execute stage register; forward a write to the entry read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_step     <= step;
      b_fwd      <= we && (waddr == raddr);
      b_fwd_data <= wdata;
    end
  end

  // Modify
  assign old   = b_fwd ? b_fwd_data : (rd_vld ? rdata : 8'h00);
  assign upd   = (old & ~b_step.mask) | (b_step.val & b_step.mask);
  assign dbyte = (b_step.cls == CLS_RESP) ? b_step.rx_frame[15:8] :
                 (b_step.wr ? upd : 8'h00);
  assign tail  = (b_step.cls == CLS_RESP) ? b_step.rx_frame[7:5] : 3'd0;

  // CRC over data byte and the three bits ahead of the CRC field
  always_comb begin
    logic [4:0] c;
    c = b_step.crc;
    for (int i = 7; i >= 0; i--) begin
      c = crc5_step(c, dbyte[i]);
    end
    for (int i = 2; i >= 0; i--) begin
      c = crc5_step(c, tail[i]);
    end
    crc = c;
  end

  assign ok    = (crc == b_step.rx_frame[4:0]);
  assign waddr = AW'({b_step.board, b_step.reg_addr});
  assign wdata = (b_step.cls == CLS_RESP) ? b_step.rx_frame[15:8] : upd;
  assign we    = b_fire &&
                 (((b_step.cls == CLS_FRAME) && b_step.wr) ||
                  ((b_step.cls == CLS_RESP) && ok && b_step.store));

  // Result assembly
  always_comb begin
    res_next = '0;
    case (b_step.cls)
      CLS_FRAME: begin
        res_next.tx_frame = {b_step.board, 1'b0, b_step.reg_addr, b_step.wr, dbyte,
                             3'd0, crc};
        res_next.last     = b_step.last;
      end
      CLS_REJECT: begin
        res_next.bad_argument = 1'b1;
        res_next.last         = 1'b1;
      end
      default: begin
        res_next.kind        = 1'b1;
        res_next.rx_ok       = ok;
        res_next.rx_data     = dbyte;
        res_next.input_level = dbyte[b_step.chan];
        res_next.last        = 1'b1;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dio_spi_command_engine.sv */
// Top level of the SPI command engine for cascaded quad digital I/O chips.
// Depends on dsce_pkg, dsce_seq and dsce_exec.
//
// Usage:
//  - cmd channel (cmd_valid / cmd_stall / cmd) takes one command or one
//    received response frame per transfer. res channel (res_valid /
//    res_stall / res) returns the frames to send and the response checks,
//    one result per transfer; the final result of a command has last set.
//  - A command yields 1 to 16 results (init fetch gives 16), at one result
//    per cycle while res_stall is low. A command holds the command channel
//    until its last step issues; the next command is taken in the cycle its
//    predecessor issues its last step, so results of consecutive commands
//    flow without gaps. Func codes 6 and 7 are taken and produce nothing.
//  - A command passes the command register, the shadow memory read and
//    execute stage register, then modify, CRC and the output register.
//    The rate is set by the single read-modify-write path into the shadow
//    memory, one register access per cycle when not stalled.
//  - Reset clears the shadow registers to zero at once (per-entry written
//    bits), so commands are taken right after reset.
//  - When res_stall is high the output register holds its result and the
//    execute stage and sequencer wait; cmd_stall rises as needed.
`default_nettype none

module dio_spi_command_engine #(
  parameter int BOARDS = dsce_pkg::BOARDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire dsce_pkg::cmd_t    cmd,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output dsce_pkg::result_t      res
);
  import dsce_pkg::*;

  logic  step_valid;
  logic  step_take;
  step_t step;

  dsce_seq #(
    .BOARDS(BOARDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .step_valid(step_valid),
    .step      (step),
    .step_take (step_take)
  );

  dsce_exec #(
    .BOARDS(BOARDS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .step_valid(step_valid),
    .step      (step),
    .step_take (step_take),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (res_stall)
  );

endmodule

`default_nettype wire

/* rtl/core/dsce_checker.sv */
// Port-level checks for dio_spi_command_engine and the bind that attaches
// them. Depends on dsce_pkg.
`default_nettype none

module dsce_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              res_valid,
  input wire logic              res_stall,
  input wire dsce_pkg::result_t res
);
  import dsce_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // A rejected command gives a single empty frame
  a_reject: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bad_argument |->
      res.last && !res.kind && (res.tx_frame == 24'd0))
    else $error("reject result malformed");

  // A response check is always the only result of its transfer
  a_resp: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind |->
      res.last && !res.bad_argument && (res.tx_frame == 24'd0))
    else $error("response result malformed");

  // Transmit frames keep the pad bits ahead of the CRC clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.kind && !res.bad_argument |->
      (res.tx_frame[7:5] == 3'd0) && !res.rx_ok && (res.rx_data == 8'd0))
    else $error("transmit frame malformed");

  // Nothing is shown right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind dio_spi_command_engine dsce_checker u_dsce_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res)
);

`default_nettype wire

/* tb/dio_spi_command_engine_test.sv */
// Self-checking testbench for dio_spi_command_engine: random and directed commands in,
// frames and response checks out, compared against a shadow-register predictor.
// Depends on dsce_pkg and the RTL of the command engine.

module dio_spi_command_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dsce_pkg::*;

  localparam int BOARDS = BOARDS_DEF;

  // Func codes the engine ignores
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 130;
  localparam int QUIET_TAIL   = 30;
  localparam int SETTLE_TICKS = 20;

  typedef struct {
    cmd_t c;
    bit   drain;
  } pending_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cmd_valid = 1'b0;
  logic    cmd_stall;
  cmd_t    cmd = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res;

  pending_t   pending[$];
  result_t    frames_due[$];
  logic [7:0] shadow_mirror[BOARDS][REGS_PER_BOARD];
  int         fails = 0;
  bit         cmd_went = 1'b0;
  int         send_gap = 0;
  int         hold_left = 0;

  dio_spi_command_engine uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the engine hangs
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // CRC5, MSB first, over frame bits first..lastb (bit 0 is frame[23])
  function automatic logic [4:0] crc5_over(logic [23:0] frame, int first, int lastb);
    logic [4:0] crc;
    logic       top;
    crc = CRC_SEED;
    for (int i = first; i <= lastb; i++) begin
      top = crc[4];
      crc = {crc[3:0], 1'b0};
      if (frame[23 - i] ^ top) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  // Response frame with a matching check field
  function automatic logic [23:0] with_crc(logic [23:0] frame);
    return {frame[23:5], crc5_over(frame, 2, 18)};
  endfunction

  // One outgoing SPI frame: address byte, data byte, CRC byte
  function automatic result_t tx_result(logic [1:0] b, logic [3:0] r, logic wr, logic [7:0] d);
    result_t     o;
    logic [23:0] f;
    f = {b, 1'b0, r, wr, d, 8'h00};
    f[4:0] = crc5_over(f, 0, 18);
    o = '0;
    o.tx_frame = f;
    return o;
  endfunction

  function automatic void push_write(logic [1:0] b, logic [3:0] r);
    frames_due.push_back(tx_result(b, r, 1'b1, shadow_mirror[b][r]));
  endfunction

  // Update the shadow copy and queue the results one command transfer causes
  function automatic void predict_frames(cmd_t c);
    result_t    o;
    logic [7:0] d;
    logic [3:0] ri;
    if (c.func == FN_SPARE_A || c.func == FN_SPARE_B) begin
      return;
    end
    if (c.func == FN_RESPONSE) begin
      d = c.rx_frame[15:8];
      o = '0;
      o.kind = 1'b1;
      o.rx_ok = (crc5_over(c.rx_frame, 2, 18) == c.rx_frame[4:0]);
      o.rx_data = d;
      o.input_level = d[c.chan];
      o.last = 1'b1;
      if (o.rx_ok && c.store_flag && c.board < BOARDS) begin
        shadow_mirror[c.board][c.reg_addr] = d;
      end
      frames_due.push_back(o);
      return;
    end
    // Rejected command: nothing changes, one flagged result
    if (c.board >= BOARDS || (c.func == FN_SET_MODE && c.op_mode == MODE_BAD)) begin
      o = '0;
      o.bad_argument = 1'b1;
      o.last = 1'b1;
      frames_due.push_back(o);
      return;
    end
    case (c.func)
      FN_SET_MODE: begin
        if (c.op_mode < MODE_HIGH_Z) begin
          shadow_mirror[c.board][R_SETOUT][4 + c.chan] = 1'b0;
          shadow_mirror[c.board][R_CONFIGDO][2 * c.chan] = c.op_mode[0];
          shadow_mirror[c.board][R_CONFIGDO][2 * c.chan + 1] = c.op_mode[1];
          push_write(c.board, R_SETOUT);
          push_write(c.board, R_CONFIGDO);
        end else begin
          shadow_mirror[c.board][R_SETOUT][4 + c.chan] = 1'b1;
          shadow_mirror[c.board][R_CONFIGDO][2 * c.chan + 1] = (c.op_mode == MODE_HIGH_Z);
          if (c.op_mode != MODE_HIGH_Z) begin
            shadow_mirror[c.board][R_CONFIGDI][7] = (c.op_mode == MODE_DI_ALT);
          end
          push_write(c.board, R_SETOUT);
          push_write(c.board, R_CONFIGDO);
          push_write(c.board, R_CONFIGDI);
        end
      end
      FN_WRITE_LEVEL: begin
        shadow_mirror[c.board][R_SETOUT][c.chan] = c.level;
        push_write(c.board, R_SETOUT);
      end
      FN_READ_REQ: begin
        shadow_mirror[c.board][R_CONFIGDI][4] = 1'b0;
        push_write(c.board, R_CONFIGDI);
        frames_due.push_back(tx_result(c.board, R_DOILEVEL, 1'b0, 8'h00));
      end
      FN_INIT_FETCH: begin
        for (int i = 0; i < REGS_PER_BOARD; i++) begin
          ri = 4'(i);
          frames_due.push_back(tx_result(c.board, ri, 1'b0, 8'h00));
        end
      end
      default: begin
        shadow_mirror[c.board][R_CONFIG1][1:0] = 2'b00;
        push_write(c.board, R_CONFIG1);
        shadow_mirror[c.board][R_OPNWREN] = shadow_mirror[c.board][R_OPNWREN] | 8'hf0;
        push_write(c.board, R_OPNWREN);
        shadow_mirror[c.board][R_CURRLIM] = 8'hff;
        push_write(c.board, R_CURRLIM);
      end
    endcase
    frames_due[frames_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void push_item(logic [2:0] f, logic [1:0] b, logic [1:0] ch,
                                    logic [2:0] m, logic l, logic [3:0] r, logic s,
                                    logic [23:0] fr, bit drain);
    pending_t p;
    p.c.func = f;
    p.c.board = b;
    p.c.chan = ch;
    p.c.op_mode = m;
    p.c.level = l;
    p.c.reg_addr = r;
    p.c.store_flag = s;
    p.c.rx_frame = fr;
    p.drain = drain;
    pending.push_back(p);
  endfunction

  function automatic bit winding_down();
    return pending.size() < QUIET_TAIL;
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  // Command driver: next transfer only once the current one is taken
  always @(negedge clk) begin : feed_cmds
    pending_t head;
    if (!rst && (!cmd_valid || cmd_went)) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (pending.size() != 0 && !(pending[0].drain && frames_due.size() != 0)) begin
        head = pending.pop_front();
        cmd <= head.c;
        cmd_valid <= 1'b1;
        if (!winding_down() && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 10);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (!winding_down() && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 9);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Monitor: predict on each command transfer, check each result transfer
  always @(posedge clk) begin : watch_ports
    result_t want;
    cmd_went = !rst && cmd_valid && !cmd_stall;
    if (cmd_went) begin
      predict_frames(cmd);
    end
    if (!rst && res_valid && !res_stall) begin
      if (frames_due.size() == 0) begin
        $error("result with none expected: %p", res);
        fails++;
      end else begin
        want = frames_due.pop_front();
        check_field("kind", 24'(want.kind), 24'(res.kind));
        check_field("tx_frame", want.tx_frame, res.tx_frame);
        check_field("rx_ok", 24'(want.rx_ok), 24'(res.rx_ok));
        check_field("rx_data", 24'(want.rx_data), 24'(res.rx_data));
        check_field("input_level", 24'(want.input_level), 24'(res.input_level));
        check_field("bad_argument", 24'(want.bad_argument), 24'(res.bad_argument));
        check_field("last", 24'(want.last), 24'(res.last));
      end
    end
  end

  initial begin : stimulus
    cmd_t        c;
    logic [63:0] raw;
    int          counted;
    int          roll;
    foreach (shadow_mirror[b, r]) begin
      shadow_mirror[b][r] = 8'h00;
    end

    // Directed: every mode including the invalid one, on all boards and channels
    for (int m = 0; m < 8; m++) begin
      push_item(FN_SET_MODE, m[1:0], ~m[1:0], m[2:0], 1'b0, 4'h0, 1'b0, 24'h000000, 1'b0);
    end
    push_item(FN_WRITE_LEVEL, 2'd3, 2'd3, 3'd0, 1'b1, 4'hf, 1'b1, 24'hffffff, 1'b0);
    push_item(FN_WRITE_LEVEL, 2'd0, 2'd0, 3'd7, 1'b0, 4'h0, 1'b0, 24'h000000, 1'b0);
    push_item(FN_READ_REQ, 2'd2, 2'd1, 3'd0, 1'b0, 4'h0, 1'b0, 24'h000000, 1'b0);
    push_item(FN_RESPONSE, 2'd2, 2'd1, 3'd0, 1'b0, R_DOILEVEL, 1'b1,
              with_crc(24'h05ff00), 1'b0);
    // good response stored into a config register, then merged by a mode change
    push_item(FN_RESPONSE, 2'd2, 2'd3, 3'd0, 1'b0, R_CONFIGDO, 1'b1,
              with_crc(24'h5ac3e0), 1'b0);
    push_item(FN_SET_MODE, 2'd2, 2'd0, 3'd5, 1'b0, 4'h0, 1'b0, 24'h000000, 1'b0);
    // corrupt and all-zero responses with store requested
    push_item(FN_RESPONSE, 2'd1, 2'd3, 3'd7, 1'b1, R_SETOUT, 1'b1, 24'hffffff, 1'b0);
    push_item(FN_RESPONSE, 2'd0, 2'd0, 3'd0, 1'b0, R_SETOUT, 1'b1, 24'h000000, 1'b0);
    // good response without store
    push_item(FN_RESPONSE, 2'd3, 2'd0, 3'd0, 1'b0, R_CURRLIM, 1'b0,
              with_crc(24'h008100), 1'b0);
    push_item(FN_INIT_FETCH, 2'd3, 2'd2, 3'd0, 1'b0, 4'h0, 1'b0, 24'h000000, 1'b0);
    push_item(FN_INIT_APPLY, 2'd1, 2'd2, 3'd0, 1'b0, 4'h0, 1'b0, 24'h000000, 1'b0);
    push_item(FN_SPARE_A, 2'd1, 2'd1, 3'd1, 1'b1, 4'h5, 1'b1, 24'h123456, 1'b0);
    push_item(FN_SPARE_B, 2'd2, 2'd2, 3'd2, 1'b0, 4'ha, 1'b0, 24'hedcba9, 1'b0);
    push_item(FN_WRITE_LEVEL, 2'd1, 2'd2, 3'd0, 1'b1, 4'h0, 1'b0, 24'h000000, 1'b1);

    // Random: mostly well-formed commands, read requests followed by their reply
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      raw = {$urandom, $urandom};
      c = raw[39:0];
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        c.func = roll[0] ? FN_SPARE_A : FN_SPARE_B;
        push_item(c.func, c.board, c.chan, c.op_mode, c.level, c.reg_addr, c.store_flag,
                  c.rx_frame, 1'b0);
      end else begin
        if (roll < 25) begin
          c.func = FN_SET_MODE;
        end else if (roll < 40) begin
          c.func = FN_WRITE_LEVEL;
        end else if (roll < 54) begin
          c.func = FN_READ_REQ;
        end else if (roll < 60) begin
          c.func = FN_INIT_FETCH;
        end else if (roll < 68) begin
          c.func = FN_INIT_APPLY;
        end else begin
          c.func = FN_RESPONSE;
          if ($urandom_range(0, 9) < 7) begin
            c.rx_frame = with_crc(c.rx_frame);
          end
        end
        push_item(c.func, c.board, c.chan, c.op_mode, c.level, c.reg_addr, c.store_flag,
                  c.rx_frame, (counted % 50) == 25);
        counted++;
        if (c.func == FN_READ_REQ) begin
          push_item(FN_RESPONSE, c.board, c.chan, c.op_mode, c.level, R_DOILEVEL,
                    raw[63], with_crc(raw[63:40]), 1'b0);
          counted++;
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every transfer to go out and every result to come back
    while (pending.size() != 0 || cmd_valid || frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(negedge clk);

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dsce_pkg.sv
rtl/core/dsce_seq.sv
rtl/core/dsce_exec.sv
rtl/core/dio_spi_command_engine.sv
rtl/core/dsce_checker.sv
tb/dio_spi_command_engine_test.sv
